/* src/sequence_range_set_defines.svh */
// Assertion macros used by the checker file
`ifndef SEQUENCE_RANGE_SET_DEFINES_SVH
`define SEQUENCE_RANGE_SET_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted
`define SRS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sequence_range_set assertion failed");

// Clocked assertion that also holds during reset
`define SRS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("sequence_range_set assertion failed");

`endif

/* src/srs_pkg.sv */
// Types and constants of the range set
package srs_pkg;

  localparam int unsigned MAX_RANGES = 64;
  localparam int unsigned CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int unsigned IDX_W      = $clog2(MAX_RANGES);
  localparam int unsigned PADDR_W    = 2;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_TEST  = 2'd1,
    FUNC_NEXT  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_CLEAR,
    ST_T_CHK,
    ST_T_CUR,
    ST_T_NXT,
    ST_B_CHK,
    ST_B_CMP,
    ST_N_CHK,
    ST_N_CMP,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ADD,
    CMD_CLEAR,
    CMD_RD_CUR,
    CMD_RD_NXT,
    CMD_CUR_INC,
    CMD_RD_MID,
    CMD_BS_LEFT,
    CMD_BS_RIGHT,
    CMD_FOUND_MID,
    CMD_SET_MEMBER,
    CMD_RD_IDX,
    CMD_N_STEP,
    CMD_N_HIT,
    CMD_N_END
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } srs_cmd_t;

  typedef struct packed {
    func_e func;
    logic  test_out;     // empty table or number outside first..last
    logic  gt_rd_high;
    logic  lt_rd_low;
    logic  in_rd;
    logic  cur_is_last;
    logic  bs_done;
    logic  n_exhausted;
    logic  idx_end;
    logic  cand_hit;
    logic  out_busy;
  } srs_stat_t;

endpackage

/* src/srs_ctrl.sv */
// Sequencer for the range set operations
module srs_ctrl
  import srs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  srs_stat_t stat_i,
  output srs_cmd_t  cmd_o,
  output logic      done_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign done_o     = (state_q == ST_DONE);

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = CMD_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = ST_T_CHK;
        end
      end
      ST_T_CHK: begin
        // func is known only after the load
        case (stat_i.func)
          FUNC_ADD:   state_d = ST_ADD;
          FUNC_NEXT:  state_d = ST_N_CHK;
          FUNC_CLEAR: state_d = ST_CLEAR;
          default: begin
            if (stat_i.test_out) begin
              state_d = ST_DONE;
            end else begin
              cmd_o.op = CMD_RD_CUR;
              state_d  = ST_T_CUR;
            end
          end
        endcase
      end
      ST_ADD: begin
        cmd_o.op = CMD_ADD;
        state_d  = ST_DONE;
      end
      ST_CLEAR: begin
        cmd_o.op = CMD_CLEAR;
        state_d  = ST_DONE;
      end
      ST_T_CUR: begin
        if (stat_i.gt_rd_high) begin
          if (stat_i.cur_is_last) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.op = CMD_RD_NXT;
            state_d  = ST_T_NXT;
          end
        end else if (stat_i.in_rd) begin
          cmd_o.op = CMD_SET_MEMBER;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_B_CHK;
        end
      end
      ST_T_NXT: begin
        if (stat_i.lt_rd_low) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.op = CMD_CUR_INC;
          state_d  = stat_i.in_rd ? ST_DONE : ST_B_CHK;
        end
      end
      ST_B_CHK: begin
        if (stat_i.bs_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.op = CMD_RD_MID;
          state_d  = ST_B_CMP;
        end
      end
      ST_B_CMP: begin
        state_d = ST_B_CHK;
        if (stat_i.lt_rd_low) begin
          cmd_o.op = CMD_BS_LEFT;
        end else if (stat_i.gt_rd_high) begin
          cmd_o.op = CMD_BS_RIGHT;
        end else begin
          cmd_o.op = CMD_FOUND_MID;
          state_d  = ST_DONE;
        end
      end
      ST_N_CHK: begin
        if (stat_i.n_exhausted || stat_i.idx_end) begin
          cmd_o.op = CMD_N_END;
          state_d  = ST_DONE;
        end else begin
          cmd_o.op = CMD_RD_IDX;
          state_d  = ST_N_CMP;
        end
      end
      ST_N_CMP: begin
        if (stat_i.cand_hit) begin
          cmd_o.op = CMD_N_HIT;
          state_d  = ST_DONE;
        end else begin
          cmd_o.op = CMD_N_STEP;
          state_d  = ST_N_CHK;
        end
      end
      ST_DONE: begin
        // result register is loaded in the datapath once it is free
        if (!stat_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* src/srs_dpath.sv */
// Range tables, set state and result register
module srs_dpath
  import srs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        merge_i,
  input  srs_cmd_t    cmd_i,
  input  logic        done_i,
  output srs_stat_t   stat_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] number_i,
  input  logic        member_flag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_member_o,
  output logic [31:0] next_value_o,
  output logic        end_reached_o,
  output logic        overflow_o,
  output logic [31:0] first_value_o,
  output logic [31:0] last_value_o,
  output logic [31:0] first_gap_o
);

  logic [31:0] mem_low  [MAX_RANGES];
  logic [31:0] mem_high [MAX_RANGES];

  logic [1:0]       func_q;
  logic [31:0]      num_q, last_q, cand_q;
  logic             inc_q;
  logic [CNT_W-1:0] count_q, bs_lo_q, bs_hi_q, idx_q;
  logic [IDX_W-1:0] cur_q, mid_q;
  logic [31:0]      first_low_q, first_high_q, last_high_q;
  logic [31:0]      rd_low_q, rd_high_q;
  logic             member_q, endr_q, ovf_q;
  logic [31:0]      nextv_q;
  logic             out_valid_q;

  // read port and write port controls
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_low, wr_high;
  logic [IDX_W-1:0] wr_addr;

  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] cur_ext;
  logic [31:0]      cand_raised;

  // add decode
  logic        add_repeat, add_skip, add_fresh, add_full, add_write;
  logic [31:0] add_prev;

  assign mid_sum     = {1'b0, bs_lo_q} + {1'b0, bs_hi_q};
  assign cur_ext     = CNT_W'(cur_q);
  assign cand_raised = (cand_q < rd_low_q) ? rd_low_q : cand_q;

  always_comb begin
    add_repeat = inc_q && (num_q == last_q) && (count_q != '0) && (last_high_q == num_q);
    add_skip   = (num_q > last_q) && !inc_q;
    add_prev   = ((num_q > last_q) && !merge_i) ? num_q - 32'd1 : last_q;
    add_fresh  = (count_q == '0) || (last_high_q < add_prev) || (num_q <= add_prev);
    add_full   = add_fresh && (count_q == CNT_W'(MAX_RANGES));
    add_write  = (cmd_i.op == CMD_ADD) && !add_repeat && !add_skip && !add_full;
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_q;
    case (cmd_i.op)
      CMD_RD_CUR: rd_en = 1'b1;
      CMD_RD_NXT: begin
        rd_en   = 1'b1;
        rd_addr = cur_q + IDX_W'(1);
      end
      CMD_RD_MID: begin
        rd_en   = 1'b1;
        rd_addr = mid_sum[IDX_W:1];
      end
      CMD_RD_IDX: begin
        rd_en   = 1'b1;
        rd_addr = idx_q[IDX_W-1:0];
      end
      default: rd_en = 1'b0;
    endcase
    wr_low  = add_write && add_fresh;
    wr_high = add_write;
    wr_addr = add_fresh ? count_q[IDX_W-1:0] : IDX_W'(count_q - CNT_W'(1));
  end

  // range tables
  always_ff @(posedge clk_i) begin
    if (wr_low) begin
      mem_low[wr_addr] <= num_q;
    end
    if (wr_high) begin
      mem_high[wr_addr] <= num_q;
    end
    if (rd_en) begin
      rd_low_q  <= mem_low[rd_addr];
      rd_high_q <= mem_high[rd_addr];
    end
  end

  // transaction fields and scratch registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        func_q   <= func_i;
        num_q    <= number_i;
        inc_q    <= member_flag_i;
        member_q <= 1'b0;
        nextv_q  <= '0;
        endr_q   <= 1'b0;
        ovf_q    <= 1'b0;
        bs_lo_q  <= '0;
        bs_hi_q  <= count_q;
        cand_q   <= last_q + 32'd1;
        idx_q    <= cur_ext;
      end
      CMD_ADD:        ovf_q <= add_full && !add_repeat && !add_skip;
      CMD_RD_MID:     mid_q <= mid_sum[IDX_W:1];
      CMD_BS_LEFT:    bs_hi_q <= CNT_W'(mid_q);
      CMD_BS_RIGHT:   bs_lo_q <= CNT_W'(mid_q) + CNT_W'(1);
      CMD_FOUND_MID:  member_q <= 1'b1;
      CMD_SET_MEMBER: member_q <= 1'b1;
      CMD_CUR_INC:    member_q <= stat_o.in_rd;
      CMD_N_STEP: begin
        cand_q <= cand_raised;
        idx_q  <= idx_q + CNT_W'(1);
      end
      CMD_N_HIT:      nextv_q <= cand_raised;
      CMD_N_END:      endr_q <= 1'b1;
      default: ;
    endcase
  end

  // set state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      last_q  <= '0;
      cur_q   <= '0;
    end else begin
      case (cmd_i.op)
        CMD_CLEAR: begin
          count_q <= '0;
          last_q  <= '0;
          cur_q   <= '0;
        end
        CMD_ADD: begin
          if (add_skip && !add_repeat) begin
            last_q <= num_q;
          end else if (add_write) begin
            last_q <= num_q;
            if (add_fresh) begin
              count_q <= count_q + CNT_W'(1);
            end
          end
        end
        CMD_CUR_INC:   cur_q <= cur_q + IDX_W'(1);
        CMD_FOUND_MID: cur_q <= mid_q;
        CMD_N_HIT: begin
          cur_q  <= idx_q[IDX_W-1:0];
          last_q <= cand_raised;
        end
        CMD_N_END:     last_q <= ALL_ONES;
        default: ;
      endcase
    end
  end

  // copies of the first and last range ends for the summary fields
  always_ff @(posedge clk_i) begin
    if (add_write) begin
      last_high_q <= num_q;
      if (add_fresh && (count_q == '0)) begin
        first_low_q  <= num_q;
        first_high_q <= num_q;
      end else if (!add_fresh && (count_q == CNT_W'(1))) begin
        first_high_q <= num_q;
      end
    end
  end

  // status toward the sequencer
  always_comb begin
    stat_o.func        = func_e'(func_q);
    stat_o.test_out    = (count_q == '0) || (num_q < first_low_q) || (num_q > last_high_q);
    stat_o.gt_rd_high  = num_q > rd_high_q;
    stat_o.lt_rd_low   = num_q < rd_low_q;
    stat_o.in_rd       = (num_q >= rd_low_q) && (num_q <= rd_high_q);
    stat_o.cur_is_last = (cur_ext + CNT_W'(1)) >= count_q;
    stat_o.bs_done     = bs_lo_q >= bs_hi_q;
    stat_o.n_exhausted = last_q == ALL_ONES;
    stat_o.idx_end     = idx_q >= count_q;
    stat_o.cand_hit    = cand_raised <= rd_high_q;
    stat_o.out_busy    = out_valid_q && !out_ready_i;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_i && !stat_o.out_busy) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_i && !stat_o.out_busy) begin
      is_member_o   <= member_q;
      next_value_o  <= nextv_q;
      end_reached_o <= endr_q;
      overflow_o    <= ovf_q;
      first_value_o <= (count_q != '0) ? first_low_q : '0;
      last_value_o  <= (count_q != '0) ? last_high_q : '0;
      first_gap_o   <= ((count_q != '0) && (first_low_q == 32'd1)) ?
                       first_high_q + 32'd1 : 32'd1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/sequence_range_set.sv */
// Sorted range set: top level with configuration port
// Transaction steps, from acceptance to the next acceptance:
//   add and clear load, act and finish; test checks the bounds, the current and the following
//   range, then runs a binary search over the range table through the registered table read
//   port; next scans the ranges one by one. A stalled result holds the sequencer in its done state.
// Throughput: one transaction at a time; the next is taken when the result is loaded.
// Reset: asynchronous, active low; empties the set and clears merge_mode, no table sweep.
module sequence_range_set
  import srs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [31:0]        number_i,
  input  logic               member_flag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               is_member_o,
  output logic [31:0]        next_value_o,
  output logic               end_reached_o,
  output logic               overflow_o,
  output logic [31:0]        first_value_o,
  output logic [31:0]        last_value_o,
  output logic [31:0]        first_gap_o
);

  logic      merge_q;
  srs_cmd_t  cmd;
  srs_stat_t stat;
  logic      done;

  // configuration register at address 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == '0)) begin
      merge_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == '0) ? {31'd0, merge_q} : 32'd0;

  srs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .done_o     (done)
  );

  srs_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .merge_i       (merge_q),
    .cmd_i         (cmd),
    .done_i        (done),
    .stat_o        (stat),
    .func_i        (func_i),
    .number_i      (number_i),
    .member_flag_i (member_flag_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_member_o   (is_member_o),
    .next_value_o  (next_value_o),
    .end_reached_o (end_reached_o),
    .overflow_o    (overflow_o),
    .first_value_o (first_value_o),
    .last_value_o  (last_value_o),
    .first_gap_o   (first_gap_o)
  );

endmodule

/* src/srs_checker.sv */
// Port-level checks for the range set, bound to the top level
`include "sequence_range_set_defines.svh"

module srs_checker
  import srs_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               is_member_o,
  input logic [31:0]        next_value_o,
  input logic               end_reached_o,
  input logic               overflow_o,
  input logic [31:0]        first_value_o,
  input logic [31:0]        first_gap_o
);

  // a stalled result holds
  `SRS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_value_o))
  // end of iteration always reports zero
  `SRS_ASSERT(a_end_zero, out_valid_o && end_reached_o |-> next_value_o == 32'd0)
  // a run not starting at one has gap one
  `SRS_ASSERT(a_gap_one, out_valid_o && first_value_o != 32'd1 |-> first_gap_o == 32'd1)
  // a membership hit carries no other operation's flags
  `SRS_ASSERT(a_member_only, out_valid_o && is_member_o |-> !end_reached_o && !overflow_o)

endmodule

bind sequence_range_set srs_checker u_srs_checker (.*);

/* tb/sv/sequence_range_set_tb.sv */
// Testbench for the sorted range set: scoreboard class and handshake drivers
`timescale 1ns / 100ps

module sequence_range_set_tb;
  import srs_pkg::*;

  typedef struct packed {
    logic        is_member;
    logic [31:0] next_value;
    logic        end_reached;
    logic        overflow;
    logic [31:0] first_value;
    logic [31:0] last_value;
    logic [31:0] first_gap;
  } rset_result_t;

  // Scoreboard: shadow range table plus queue of predicted results
  class rset_scoreboard;
    logic [31:0]  lo_tab [MAX_RANGES];
    logic [31:0]  hi_tab [MAX_RANGES];
    int unsigned  count;
    logic [31:0]  last_num;
    int unsigned  cur;
    logic         merge;
    rset_result_t pending[$];
    int           errors;

    function new();
      count = 0; last_num = 32'd0; cur = 0; merge = 1'b0; errors = 0;
    endfunction

    function logic do_add(logic [31:0] num, logic inc);
      logic [31:0] prev;
      logic fresh;
      prev = last_num;
      if (inc && num == prev && count > 0 && hi_tab[count-1] == num) return 1'b0;
      if (num > prev) begin
        if (!inc) begin
          last_num = num;
          return 1'b0;
        end
        if (!merge) prev = num - 32'd1;
      end
      fresh = (count == 0) || (hi_tab[count-1] < prev) || (num <= prev);
      if (fresh) begin
        if (count >= MAX_RANGES) return 1'b1;
        lo_tab[count] = num;
        count++;
      end
      hi_tab[count-1] = num;
      last_num = num;
      return 1'b0;
    endfunction

    function logic do_test(logic [31:0] num);
      int unsigned c, l, h, m;
      c = cur; l = 0; h = count;
      if (count == 0) return 1'b0;
      if (num < lo_tab[0] || num > hi_tab[count-1]) return 1'b0;
      if (num > hi_tab[c]) begin
        if (c + 1 >= count) return 1'b0;
        if (num < lo_tab[c+1]) return 1'b0;
        c++;
        cur = c;
      end
      if (num >= lo_tab[c] && num <= hi_tab[c]) return 1'b1;
      while (l < h) begin
        m = (l + h) / 2;
        if (num < lo_tab[m]) h = m;
        else if (num > hi_tab[m]) l = m + 1;
        else begin
          cur = m;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function logic [31:0] do_next();
      logic [31:0] num;
      if (last_num == ALL_ONES) return 32'd0;
      num = last_num + 32'd1;
      for (int unsigned i = cur; i < count; i++) begin
        if (num < lo_tab[i]) num = lo_tab[i];
        if (num <= hi_tab[i]) begin
          cur = i;
          last_num = num;
          return num;
        end
      end
      last_num = ALL_ONES;
      return 32'd0;
    endfunction

    // Predict the result of one accepted input transaction
    function void note_input(func_e f, logic [31:0] num, logic inc);
      rset_result_t r;
      r = '0;
      r.first_gap = 32'd1;
      case (f)
        FUNC_ADD:  r.overflow = do_add(num, inc);
        FUNC_TEST: r.is_member = do_test(num);
        FUNC_NEXT: begin
          r.next_value = do_next();
          r.end_reached = (r.next_value == 32'd0);
        end
        default: begin
          count = 0; last_num = 32'd0; cur = 0;
        end
      endcase
      if (count > 0) begin
        r.first_value = lo_tab[0];
        r.last_value = hi_tab[count-1];
        if (lo_tab[0] == 32'd1) r.first_gap = hi_tab[0] + 32'd1;
      end
      pending.push_back(r);
    endfunction

    // Compare one accepted result against the oldest prediction
    function void check_result(rset_result_t act);
      rset_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (exp.is_member !== act.is_member) begin
        $display("%0t: is_member exp %h act %h", $time, exp.is_member, act.is_member);
        errors++;
      end
      if (exp.next_value !== act.next_value) begin
        $display("%0t: next_value exp %h act %h", $time, exp.next_value, act.next_value);
        errors++;
      end
      if (exp.end_reached !== act.end_reached) begin
        $display("%0t: end_reached exp %h act %h", $time, exp.end_reached,
                 act.end_reached);
        errors++;
      end
      if (exp.overflow !== act.overflow) begin
        $display("%0t: overflow exp %h act %h", $time, exp.overflow, act.overflow);
        errors++;
      end
      if (exp.first_value !== act.first_value) begin
        $display("%0t: first_value exp %h act %h", $time, exp.first_value,
                 act.first_value);
        errors++;
      end
      if (exp.last_value !== act.last_value) begin
        $display("%0t: last_value exp %h act %h", $time, exp.last_value, act.last_value);
        errors++;
      end
      if (exp.first_gap !== act.first_gap) begin
        $display("%0t: first_gap exp %h act %h", $time, exp.first_gap, act.first_gap);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] func_i = '0;
  logic [31:0] number_i = '0;
  logic member_flag_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic is_member_o, end_reached_o, overflow_o;
  logic [31:0] next_value_o, first_value_o, last_value_o, first_gap_o;

  rset_scoreboard sb = new();
  int unsigned cycles = 0;
  logic [31:0] seq_num = '0;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  always #6 clk_i = ~clk_i;

  sequence_range_set dut (.*);

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** sequence_range_set: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, check at accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{is_member_o, next_value_o, end_reached_o, overflow_o,
                        first_value_o, last_value_o, first_gap_o});
  end

  int unsigned stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  task automatic write_mode(logic m);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= '0; pwdata <= {31'd0, m};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.merge = m;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send(func_e f, logic [31:0] num, logic inc);
    int unsigned g;
    g = gap_len();
    @(negedge clk_i);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1; func_i <= f; number_i <= num; member_flag_i <= inc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(f, num, inc);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Random item, mostly rising adds with tests and walks around them
  task automatic send_random();
    int unsigned k;
    logic [31:0] n;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      seq_num = seq_num + $urandom_range(0, 3);
      send(FUNC_ADD, seq_num, $urandom_range(0, 4) != 0);
    end else if (k < 50) begin
      send(FUNC_ADD, $urandom(), 1'($urandom_range(0, 1)));
    end else if (k < 75) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom() : seq_num - $urandom_range(0, 40);
      send(FUNC_TEST, n, 1'($urandom_range(0, 1)));
    end else if (k < 97) begin
      send(FUNC_NEXT, $urandom(), 1'($urandom_range(0, 1)));
    end else begin
      send(FUNC_CLEAR, $urandom(), 1'($urandom_range(0, 1)));
      seq_num = $urandom_range(0, 3);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes and each special case
    write_mode(1'b0);
    send(FUNC_NEXT, 32'd0, 1'b0);
    send(FUNC_TEST, 32'd5, 1'b1);
    send(FUNC_ADD, 32'd1, 1'b1);
    send(FUNC_ADD, 32'd1, 1'b1);
    send(FUNC_ADD, 32'd2, 1'b1);
    send(FUNC_ADD, 32'd5, 1'b1);
    send(FUNC_ADD, 32'd7, 1'b0);
    send(FUNC_ADD, 32'd3, 1'b0);
    send(FUNC_ADD, 32'd2, 1'b1);
    send(FUNC_TEST, 32'd2, 1'b1);
    send(FUNC_TEST, 32'd5, 1'b0);
    send(FUNC_TEST, 32'd4, 1'b0);
    send(FUNC_NEXT, ALL_ONES, 1'b1);
    send(FUNC_NEXT, 32'd0, 1'b0);
    send(FUNC_ADD, ALL_ONES, 1'b1);
    send(FUNC_NEXT, 32'd0, 1'b1);
    send(FUNC_NEXT, 32'd0, 1'b1);
    send(FUNC_CLEAR, ALL_ONES, 1'b1);
    drain();
    write_mode(1'b1);
    send(FUNC_ADD, 32'd1, 1'b1);
    send(FUNC_ADD, 32'd4, 1'b1);
    send(FUNC_ADD, 32'd6, 1'b0);
    send(FUNC_ADD, 32'd9, 1'b1);
    send(FUNC_ADD, ALL_ONES, 1'b1);
    send(FUNC_TEST, 32'd3, 1'b1);
    send(FUNC_CLEAR, 32'd0, 1'b0);
    // Add MAX_RANGES + 3 rising numbers with alternating member flag
    for (int i = 0; i < MAX_RANGES + 3; i++) send(FUNC_ADD, 32'(10 * i + 1), 1'(i % 2));
    send(FUNC_TEST, 32'd200, 1'b0);
    drain();

    // Random phases across both modes
    for (int p = 0; p < 6; p++) begin
      write_mode(1'(p % 2));
      send(FUNC_CLEAR, 32'd0, 1'b0);
      seq_num = $urandom_range(0, 2);
      for (int i = 0; i < 100; i++) send_random();
      drain();
    end

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** sequence_range_set: PASSED **");
    end else begin
      $display("** sequence_range_set: FAILED **");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+src
src/srs_pkg.sv
src/srs_ctrl.sv
src/srs_dpath.sv
src/sequence_range_set.sv
src/srs_checker.sv
tb/sv/sequence_range_set_tb.sv
